/* src/lmcd_pkg.sv */
// ----------------------------------------------------------------------------
// lmcd_pkg: shared types and constants of the LED matrix command decoder
// Holds the command codes, the display RAM size and the control state record
// that the decode logic and the top level both use.
// ----------------------------------------------------------------------------
package lmcd_pkg;

   // Number of display RAM bytes; the pointer wraps at this size (2 to 16).
   localparam int RAM_BYTES = 16;
   localparam logic [4:0] RAM_SIZE = 5'(RAM_BYTES);

   // Command codes in the high nibble of the first byte of a transfer.
   localparam logic [3:0] OP_RAM  = 4'h0;
   localparam logic [3:0] OP_OSC  = 4'h2;
   localparam logic [3:0] OP_DISP = 4'h8;
   localparam logic [3:0] OP_PIN  = 4'ha;
   localparam logic [3:0] OP_DIM  = 4'he;

   // Dim level after reset: full brightness.
   localparam logic [3:0] DIM_RESET = 4'hf;

   // Control state that is reported with every result.
   typedef struct packed {
      logic       osc_on;
      logic       display_on;
      logic [1:0] blink_mode;
      logic [3:0] dim_level;
      logic       int_enable;
      logic       int_active_high;
   } ctrl_type;

   // Full decoder state: control state plus the RAM write pointer.
   typedef struct packed {
      ctrl_type   ctrl;
      logic       data_mode;
      logic [3:0] ram_pointer;
   } state_type;

   // Decoder state after reset: standby, display off, no blink, full dim
   // level, row output, active-low polarity and no data run.
   localparam state_type STATE_RESET = '{
      ctrl: '{osc_on:          1'b0,
              display_on:      1'b0,
              blink_mode:      2'b00,
              dim_level:       DIM_RESET,
              int_enable:      1'b0,
              int_active_high: 1'b0},
      data_mode:   1'b0,
      ram_pointer: 4'h0
   };

   // RAM write caused by one byte.
   typedef struct packed {
      logic       ram_write;
      logic [3:0] ram_addr;
      logic [7:0] ram_data;
   } wr_type;

   // Reduces a value into the RAM address range by repeated compare and
   // subtract; at most eight steps, enough for the values up to 16 passed here.
   function automatic logic [3:0] wrap_addr(logic [4:0] value);
      logic [4:0] v;
      v = value;
      for (int i = 0; i < 8; i++) begin
         if (v >= RAM_SIZE) begin
            v = v - RAM_SIZE;
         end
      end
      return v[3:0];
   endfunction

endpackage

/* src/lmcd_decode.sv */
// ----------------------------------------------------------------------------
// lmcd_decode: command and data byte decode
// Computes the next decoder state and the RAM write for one received byte.
// ----------------------------------------------------------------------------
module lmcd_decode
   import lmcd_pkg::*;
(
   input  state_type  state_cur,
   input  logic [7:0] bus_byte,
   input  logic       first_byte,
   output state_type  state_nxt,
   output wr_type     wr
);

   logic [3:0] op;

   assign op = bus_byte[7:4];

   always_comb begin
      state_nxt = state_cur;
      wr        = '0;
      if (first_byte) begin
         // A command byte ends any data run and may update settings or load the pointer.
         state_nxt.data_mode = 1'b0;
         case (op)
            OP_OSC: begin
               state_nxt.ctrl.osc_on = bus_byte[0];
            end
            OP_DISP: begin
               state_nxt.ctrl.display_on = bus_byte[0];
               state_nxt.ctrl.blink_mode = bus_byte[2:1];
            end
            OP_PIN: begin
               state_nxt.ctrl.int_enable      = bus_byte[0];
               state_nxt.ctrl.int_active_high = bus_byte[1];
            end
            OP_DIM: begin
               state_nxt.ctrl.dim_level = bus_byte[3:0];
            end
            OP_RAM: begin
               state_nxt.ram_pointer = wrap_addr({1'b0, bus_byte[3:0]});
               state_nxt.data_mode   = 1'b1;
            end
            default: begin
               state_nxt.data_mode = 1'b0;
            end
         endcase
      end else if (state_cur.data_mode) begin
         // Data byte after a pointer load: write RAM and advance the pointer.
         wr.ram_write          = 1'b1;
         wr.ram_addr           = state_cur.ram_pointer;
         wr.ram_data           = bus_byte;
         state_nxt.ram_pointer = wrap_addr({1'b0, state_cur.ram_pointer} + 5'd1);
      end
   end

endmodule

/* src/led_matrix_command_decoder.sv */
// ----------------------------------------------------------------------------
// led_matrix_command_decoder: device-side command decoder for an LED matrix
// Decodes bus bytes into display settings and display RAM writes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one received bus byte per transaction in
//   req_tdata, with req_tuser set on the first (command) byte of a transfer.
//   The rsp channel returns exactly one transaction per request: the display
//   settings after that byte, and in rsp_tuser whether the byte writes
//   display RAM, with the address and data written.
//   A request passes the input register, then the result register; the
//   decode between them also updates the settings. Throughput is one
//   transaction per cycle while the receiver does not stall.
//   When the receiver stalls, the response holds and the input register
//   still takes one more byte; after that req_tready drops until the
//   response is taken.
//   Reset clears both pipeline stages and sets oscillator standby, display
//   off, no blink, full dim level, row output, active-low polarity and no
//   data run.
// ----------------------------------------------------------------------------
module led_matrix_command_decoder
   import lmcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] bus_byte
   input  logic        req_tuser,   // [0] first_byte
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] osc_on, [1] display_on, [3:2] blink_mode,
                                    // [7:4] dim_level, [8] int_enable,
                                    // [9] int_active_high, [13:10] ram_addr,
                                    // [21:14] ram_data, [23:22] zero
   output logic        rsp_tuser    // [0] ram_write
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       out_valid_ff, out_valid_in;
   ctrl_type   out_ctrl_ff;
   wr_type     out_wr_ff;
   state_type  state_ff, state_in;
   wr_type     dec_wr;
   logic       out_ready;
   logic       advance;

   // The result register frees when empty or taken; the input register
   // frees when empty or moving on.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   // Decode of the byte in the input register against the current state.
   lmcd_decode u_decode (
      .state_cur  (state_ff),
      .bus_byte   (in_byte_ff),
      .first_byte (in_first_ff),
      .state_nxt  (state_in),
      .wr         (dec_wr)
   );

   // Valid bits of both stages.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
   end

   // Control registers: stage valids and decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
      if (advance) begin
         out_ctrl_ff <= state_in.ctrl;
         out_wr_ff   <= dec_wr;
      end
   end

   // Response packing.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_wr_ff.ram_write;
   assign rsp_tdata  = {2'b00,
                        out_wr_ff.ram_data,
                        out_wr_ff.ram_addr,
                        out_ctrl_ff.int_active_high,
                        out_ctrl_ff.int_enable,
                        out_ctrl_ff.dim_level,
                        out_ctrl_ff.blink_mode,
                        out_ctrl_ff.display_on,
                        out_ctrl_ff.osc_on};

endmodule

/* src/lmcd_checker.sv */
// ----------------------------------------------------------------------------
// lmcd_checker: port-level checks of the LED matrix command decoder
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module lmcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Reset empties the result stage.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Without a RAM write, the address and data fields read zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[21:10] == 12'd0)
      else $error("RAM fields set without a write");

   // A request accepted into an empty pipeline reaches the response through
   // the input and result registers when the receiver is not stalling.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("response missing two cycles after request");

endmodule

bind led_matrix_command_decoder lmcd_checker u_lmcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/lmcd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmcd_scoreboard: response checker for the LED matrix command decoder
// Watches both streams of the decoder, works out the settings and the RAM
// write that each accepted bus byte should produce, and compares every
// response transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lmcd_scoreboard
   import lmcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          pending,
   output int          failures
);

   // One response as the decoder reports it.
   typedef struct packed {
      ctrl_type ctrl;
      wr_type   wr;
   } result_type;

   // Predicted decoder state.
   ctrl_type   settings;
   logic       run_open;
   logic [3:0] write_ptr;

   result_type predicted_q[$];
   int         mismatch_count;

   // Applies one bus byte to the predicted state and returns the response
   // that the decoder should give for it.
   function automatic result_type decode_byte(logic [7:0] bus_byte, logic first_byte);
      result_type r;
      r.wr = '0;
      if (first_byte) begin
         run_open = 1'b0;
         case (bus_byte[7:4])
            OP_OSC: begin
               settings.osc_on = bus_byte[0];
            end
            OP_DISP: begin
               settings.display_on = bus_byte[0];
               settings.blink_mode = bus_byte[2:1];
            end
            OP_PIN: begin
               settings.int_enable      = bus_byte[0];
               settings.int_active_high = bus_byte[1];
            end
            OP_DIM: begin
               settings.dim_level = bus_byte[3:0];
            end
            OP_RAM: begin
               write_ptr = 4'(int'(bus_byte[3:0]) % RAM_BYTES);
               run_open  = 1'b1;
            end
            default: begin
               // Unknown commands change nothing but end any data run.
            end
         endcase
      end else if (run_open) begin
         r.wr.ram_write = 1'b1;
         r.wr.ram_addr  = write_ptr;
         r.wr.ram_data  = bus_byte;
         write_ptr      = 4'((int'(write_ptr) + 1) % RAM_BYTES);
      end
      r.ctrl = settings;
      return r;
   endfunction

   // Counts a mismatch and reports the first ten of them.
   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Mismatch on %s: expected 0x%0h, actual 0x%0h", field, want, got);
         end
      end
   endtask

   // Prediction and comparison, both on the values sampled at the clock edge.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         settings           = '0;
         settings.dim_level = DIM_RESET;
         run_open           = 1'b0;
         write_ptr          = '0;
         predicted_q.delete();
         mismatch_count     = 0;
      end else begin
         // Response transaction: compare with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.ctrl.osc_on          = rsp_tdata[0];
            got.ctrl.display_on      = rsp_tdata[1];
            got.ctrl.blink_mode      = rsp_tdata[3:2];
            got.ctrl.dim_level       = rsp_tdata[7:4];
            got.ctrl.int_enable      = rsp_tdata[8];
            got.ctrl.int_active_high = rsp_tdata[9];
            got.wr.ram_addr          = rsp_tdata[13:10];
            got.wr.ram_data          = rsp_tdata[21:14];
            got.wr.ram_write         = rsp_tuser;
            if (predicted_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response transaction: data 0x%0h, user %0b",
                           rsp_tdata, rsp_tuser);
               end
            end else begin
               want = predicted_q.pop_front();
               compare_field("osc_on", int'(want.ctrl.osc_on), int'(got.ctrl.osc_on));
               compare_field("display_on", int'(want.ctrl.display_on),
                             int'(got.ctrl.display_on));
               compare_field("blink_mode", int'(want.ctrl.blink_mode),
                             int'(got.ctrl.blink_mode));
               compare_field("dim_level", int'(want.ctrl.dim_level),
                             int'(got.ctrl.dim_level));
               compare_field("int_enable", int'(want.ctrl.int_enable),
                             int'(got.ctrl.int_enable));
               compare_field("int_active_high", int'(want.ctrl.int_active_high),
                             int'(got.ctrl.int_active_high));
               compare_field("ram_write", int'(want.wr.ram_write), int'(got.wr.ram_write));
               compare_field("ram_addr", int'(want.wr.ram_addr), int'(got.wr.ram_addr));
               compare_field("ram_data", int'(want.wr.ram_data), int'(got.wr.ram_data));
            end
         end
         // Request transaction: predict its response.
         if (req_tvalid && req_tready) begin
            predicted_q.push_back(decode_byte(req_tdata, req_tuser));
         end
      end
      pending  <= predicted_q.size();
      failures <= mismatch_count;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LED matrix command decoder
// Sends a directed set of commands and data runs, then random transfers that
// are mostly well formed, with random gaps on the request side and random
// stalls on the response side. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import lmcd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;
   localparam int ITEM_COUNT  = 520;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] bus_byte
   logic        req_tuser;    // [0] first_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [0] osc_on, [1] display_on, [3:2] blink_mode,
                              // [7:4] dim_level, [8] int_enable,
                              // [9] int_active_high, [13:10] ram_addr,
                              // [21:14] ram_data, [23:22] zero
   logic        rsp_tuser;    // [0] ram_write

   int pending;
   int failures;
   int useful;
   bit steady;
   bit hold_request;

   led_matrix_command_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lmcd_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .pending    (pending),
      .failures   (failures)
   );

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offers one byte after a random gap and waits until it is taken.
   task automatic send_byte(logic [7:0] bus_byte, logic first_byte);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bus_byte;
      req_tuser  <= first_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted response has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // A pointer load with a random start address followed by a data run.
   task automatic ram_transfer(int count);
      send_byte({OP_RAM, 4'($urandom_range(0, 15))}, 1'b1);
      useful++;
      repeat (count) begin
         send_byte(8'($urandom), 1'b0);
         useful++;
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = idle_length();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Run limit.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int         roll;
      int         count;
      bit         drained_once;
      logic [3:0] nibble;
      logic [3:0] op_pick;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      steady       = 1'b0;
      hold_request = 1'b0;
      useful       = 0;
      drained_once = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Data before any pointer load is ignored.
      send_byte(8'h5a, 1'b0);
      // Oscillator on, then a stray byte after a settings command.
      send_byte({OP_OSC, 4'h1}, 1'b1);
      send_byte(8'hff, 1'b0);
      // Display on with all blink bits and the unused bit set, then others.
      send_byte({OP_DISP, 4'hf}, 1'b1);
      send_byte({OP_DISP, 4'h7}, 1'b1);
      // Pin mode with the unused bits set and clear.
      send_byte({OP_PIN, 4'h3}, 1'b1);
      send_byte({OP_PIN, 4'hc}, 1'b1);
      // Dim level extremes.
      send_byte({OP_DIM, 4'h0}, 1'b1);
      send_byte({OP_DIM, 4'hf}, 1'b1);
      send_byte({OP_DIM, 4'h7}, 1'b1);
      // Pointer at the last address: the run wraps to zero.
      send_byte({OP_RAM, 4'hf}, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha5, 1'b0);
      // Unknown command ends the run; the following data is ignored.
      send_byte(8'h50, 1'b1);
      send_byte(8'h12, 1'b0);
      // Pointer at zero with one data byte.
      send_byte({OP_RAM, 4'h0}, 1'b1);
      send_byte(8'h01, 1'b0);
      // Settings back off, and the highest unknown command.
      send_byte({OP_DISP, 4'h0}, 1'b1);
      send_byte({OP_OSC, 4'h0}, 1'b1);
      send_byte(8'hf0, 1'b1);
      // A new command cuts a data run short.
      send_byte({OP_RAM, 4'h5}, 1'b1);
      send_byte(8'h77, 1'b0);
      send_byte({OP_OSC, 4'hf}, 1'b1);
      send_byte(8'h88, 1'b0);
      drain();

      // Long response hold-off while the request side keeps offering.
      hold_request = 1'b1;
      steady       = 1'b1;
      ram_transfer(30);
      steady       = 1'b0;

      // Random transfers, mostly well formed.
      while (useful < ITEM_COUNT) begin
         steady = (useful >= 150 && useful < 250);
         if (!drained_once && useful >= 350) begin
            drained_once = 1'b1;
            drain();
         end
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                 : $urandom_range(0, 20);
            ram_transfer(count);
         end else if (roll < 85) begin
            case ($urandom_range(0, 3))
               0:       op_pick = OP_OSC;
               1:       op_pick = OP_DISP;
               2:       op_pick = OP_PIN;
               default: op_pick = OP_DIM;
            endcase
            send_byte({op_pick, 4'($urandom_range(0, 15))}, 1'b1);
            useful++;
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
         end else begin
            // Noise: an unknown command and bytes that are ignored.
            nibble = 4'($urandom_range(0, 15));
            while (nibble inside {OP_RAM, OP_OSC, OP_DISP, OP_PIN, OP_DIM}) begin
               nibble = 4'($urandom_range(0, 15));
            end
            send_byte({nibble, 4'($urandom_range(0, 15))}, 1'b1);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
         end
      end
      steady = 1'b0;

      // Let every response arrive, then watch for stray ones.
      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
